@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file sfd_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer check failed");

// Check a property on every clock edge, reset included.
`define SFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("deframer check failed");

`endif

@@ hdl/sfd_pkg.sv @@
// Package for the sensor frame deframer: types, codes and constants.
// No dependencies.
package sfd_pkg;

    localparam int CAPTURE_BYTES_DEF = 26;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_HEADER   = 2'd2;

    localparam int N_CAP = 8;
    // bumper, wheel drop, cliff, button, distance lo/hi, angle lo/hi
    localparam logic [7:0] CAP_OFS [N_CAP] = '{
        8'd4, 8'd5, 8'd6, 8'd13, 8'd7, 8'd8, 8'd24, 8'd25
    };

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SECOND,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    typedef enum logic {
        CMD_CAPTURE,
        CMD_END
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] idx;
        logic [7:0] data;
        logic [1:0] status;
    } t_cmd;

endpackage

@@ hdl/sfd_front.sv @@
// Front end: frame parser that tracks phase, count and XOR per beat.
// Emits capture and frame-end commands; depends on sfd_pkg.
module sfd_front #(
    parameter int CAPTURE_BYTES = sfd_pkg::CAPTURE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output sfd_pkg::t_cmd o_cmd
);

    localparam logic [8:0] CAP_TOTAL = 9'(CAPTURE_BYTES);

    sfd_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_idx, n_idx;
    logic [7:0] r_len, n_len;
    logic [7:0] r_xor, n_xor;
    logic [8:0] idx_inc;
    logic [8:0] total;

    assign idx_inc = {1'b0, r_idx} + 9'd1;
    assign total   = ({1'b0, r_len} > CAP_TOTAL) ? {1'b0, r_len} : CAP_TOTAL;

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                sfd_pkg::PH_HUNT: begin
                    if (i_rx_byte == sfd_pkg::SYNC_FIRST) n_phase = sfd_pkg::PH_SECOND;
                end
                sfd_pkg::PH_SECOND: begin
                    n_phase = (i_rx_byte == sfd_pkg::SYNC_SECOND) ?
                              sfd_pkg::PH_LENGTH : sfd_pkg::PH_HUNT;
                end
                sfd_pkg::PH_LENGTH: begin
                    n_phase = sfd_pkg::PH_PAYLOAD;
                end
                sfd_pkg::PH_PAYLOAD: begin
                    if (idx_inc >= total) n_phase = sfd_pkg::PH_CHECK;
                end
                sfd_pkg::PH_CHECK: begin
                    n_phase = sfd_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = sfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        n_idx         = r_idx;
        n_len         = r_len;
        n_xor         = r_xor;
        o_push        = 1'b0;
        o_cmd.kind    = sfd_pkg::CMD_CAPTURE;
        o_cmd.idx     = r_idx;
        o_cmd.data    = i_rx_byte;
        o_cmd.status  = sfd_pkg::ST_GOOD;
        if (i_accept) begin
            case (r_phase)
                sfd_pkg::PH_SECOND: begin
                    if (i_rx_byte != sfd_pkg::SYNC_SECOND) begin
                        o_push       = 1'b1;
                        o_cmd.kind   = sfd_pkg::CMD_END;
                        o_cmd.status = sfd_pkg::ST_HEADER;
                    end
                end
                sfd_pkg::PH_LENGTH: begin
                    n_len = i_rx_byte;
                    n_xor = i_rx_byte;
                    n_idx = '0;
                end
                sfd_pkg::PH_PAYLOAD: begin
                    o_push = 1'b1;
                    n_xor  = r_xor ^ i_rx_byte;
                    n_idx  = idx_inc[7:0];
                end
                sfd_pkg::PH_CHECK: begin
                    o_push       = 1'b1;
                    o_cmd.kind   = sfd_pkg::CMD_END;
                    o_cmd.status = (r_xor == i_rx_byte) ?
                                   sfd_pkg::ST_GOOD : sfd_pkg::ST_CHECKSUM;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfd_pkg::PH_HUNT;
            r_idx   <= '0;
            r_len   <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_xor   <= n_xor;
        end
    end

endmodule

@@ hdl/sfd_queue.sv @@
// Short command queue between the parser and the capture/report back end.
// Depends on sfd_pkg.
module sfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sfd_pkg::t_cmd o_cmd
);

    localparam int DEPTH = sfd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    sfd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (do_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/sfd_back.sv @@
// Back end: captures sensor bytes, latches them on a good frame, reports.
// Depends on sfd_pkg.
module sfd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  sfd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_frame_status,
    output logic [63:0]   o_held
);

    logic [7:0]  r_cap [sfd_pkg::N_CAP];
    logic [63:0] r_held, n_held;
    logic        r_valid;
    logic [1:0]  r_status;
    logic [63:0] r_out;
    logic        slot_free;
    logic        is_end;

    assign slot_free = !r_valid || !i_stall;
    assign is_end    = (i_cmd.kind == sfd_pkg::CMD_END);
    assign o_pop     = i_cmd_valid && (!is_end || slot_free);

    always_comb begin
        n_held = r_held;
        if (o_pop && is_end && i_cmd.status == sfd_pkg::ST_GOOD) begin
            n_held = {r_cap[7], r_cap[6], r_cap[5], r_cap[4],
                      r_cap[3], r_cap[2], r_cap[1], r_cap[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sfd_pkg::N_CAP; k++) begin
            if (o_pop && !is_end && i_cmd.idx == sfd_pkg::CAP_OFS[k]) begin
                r_cap[k] <= i_cmd.data;
            end
        end
        if (o_pop && is_end) begin
            r_status <= i_cmd.status;
            r_out    <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (o_pop && is_end) r_valid <= 1'b1;
            else if (!i_stall)   r_valid <= 1'b0;
        end
    end

    assign o_valid        = r_valid;
    assign o_frame_status = r_status;
    assign o_held         = r_out;

endmodule

@@ hdl/sensor_frame_deframer.sv @@
// Top level of the sensor frame deframer: parser, command queue, back end.
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+--------------------------------
//  rx      | in        | i_valid / o_stall            | i_rx_byte
//  result  | out       | o_valid / i_stall            | o_frame_status, sensor fields
//
// One beat per cycle while o_stall is low: the parser updates phase, count and XOR on each accepted beat.
// A result passes through the command queue and then the output register after the beat that ends the frame.
// The 4-entry command queue fills only while the result stall holds a frame end back.
// Reset is synchronous, active low; it clears phase, count, XOR, the internal held word, result valid and queue.
module sensor_frame_deframer #(
    parameter int CAPTURE_BYTES = sfd_pkg::CAPTURE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_bumper_bits,
    output logic [7:0]  o_wheel_drop_bits,
    output logic [7:0]  o_cliff_bits,
    output logic [7:0]  o_button_bits,
    output logic [15:0] o_distance_ticks,
    output logic [15:0] o_angle_raw
);

    logic          accept;
    logic          push, full, pop, q_valid;
    sfd_pkg::t_cmd push_cmd, q_cmd;
    logic [63:0]   held;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    sfd_front #(
        .CAPTURE_BYTES(CAPTURE_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    sfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_held         (held)
    );

    assign o_bumper_bits     = held[7:0];
    assign o_wheel_drop_bits = held[15:8];
    assign o_cliff_bits      = held[23:16];
    assign o_button_bits     = held[31:24];
    assign o_distance_ticks  = held[47:32];
    assign o_angle_raw       = held[63:48];

endmodule

@@ hdl/sfd_checker.sv @@
// Port-level checks for the sensor frame deframer, bound to the top level.
// Depends on sfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_frame_status,
    input logic [15:0] o_distance_ticks
);

    logic [17:0] out_word;

    assign out_word = {o_frame_status, o_distance_ticks};

    `SFD_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid)
    `SFD_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    `SFD_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(out_word))
    `SFD_ASSERT(a_status_code, i_clk, i_rst_n, o_valid |-> o_frame_status <= sfd_pkg::ST_HEADER)
    `SFD_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_frame_status   (o_frame_status),
    .o_distance_ticks (o_distance_ticks)
);
